/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the 3x3 matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define M3I_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("m3i: same-cycle check failed");
`define M3I_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("m3i: next-cycle check failed");
`else
`define M3I_ASSERT_IMP(label, clk_s, rstn_s, ante, cons)
`define M3I_ASSERT_NXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

/* rtl/m3i_pkg.sv */
// Types, widths and cofactor table for the 3x3 matrix inverse block.
package m3i_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DET_WIDTH     = 48;
  localparam int THR_WIDTH     = 47;
  localparam int NUM_ENTRIES   = 9;

  // exact cofactor, exact determinant, divider working width
  localparam int COF_W  = 2 * DATA_WIDTH + 1;
  localparam int DETX_W = 3 * DATA_WIDTH + 3;
  localparam int DIV_W  = DETX_W + DATA_WIDTH;

  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

  typedef logic signed [DATA_WIDTH-1:0] entry_t;

  typedef struct packed {
    entry_t entry_r0c0;
    entry_t entry_r0c1;
    entry_t entry_r0c2;
    entry_t entry_r1c0;
    entry_t entry_r1c1;
    entry_t entry_r1c2;
    entry_t entry_r2c0;
    entry_t entry_r2c1;
    entry_t entry_r2c2;
  } in_item_t;

  typedef struct packed {
    logic signed [DET_WIDTH-1:0] det_value;
    logic                        singular;
    entry_t inv_r0c0;
    entry_t inv_r0c1;
    entry_t inv_r0c2;
    entry_t inv_r1c0;
    entry_t inv_r1c1;
    entry_t inv_r1c2;
    entry_t inv_r2c0;
    entry_t inv_r2c1;
    entry_t inv_r2c2;
  } out_item_t;

  // adjugate entry k = m[P]*m[Q] - m[S]*m[T], negated where NEG is set
  localparam int ADJ_P   [NUM_ENTRIES] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int ADJ_Q   [NUM_ENTRIES] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int ADJ_S   [NUM_ENTRIES] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int ADJ_T   [NUM_ENTRIES] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam bit ADJ_NEG [NUM_ENTRIES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

endpackage

/* rtl/m3i_cof.sv */
// Two-stage adjugate unit: 2x2 products, then signed cofactor differences.
module m3i_cof (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  m3i_pkg::entry_t                     m [m3i_pkg::NUM_ENTRIES],
  output logic                                out_valid,
  output m3i_pkg::entry_t                     row0 [3],
  output logic signed [m3i_pkg::COF_W-1:0]    cof [m3i_pkg::NUM_ENTRIES]
);
  import m3i_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;

  logic                     va_r, vb_r;
  logic signed [PROD_W-1:0] pa_r [NUM_ENTRIES];
  logic signed [PROD_W-1:0] pb_r [NUM_ENTRIES];
  entry_t                   row0a_r [3];
  entry_t                   row0b_r [3];
  logic signed [COF_W-1:0]  cof_r [NUM_ENTRIES];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // form products, then the differences
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_adj
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[k] <= m[ADJ_P[k]] * m[ADJ_Q[k]];
        pb_r[k] <= m[ADJ_S[k]] * m[ADJ_T[k]];
        if (ADJ_NEG[k]) begin
          cof_r[k] <= COF_W'(pb_r[k]) - COF_W'(pa_r[k]);
        end else begin
          cof_r[k] <= COF_W'(pa_r[k]) - COF_W'(pb_r[k]);
        end
      end
    end
    assign cof[k] = cof_r[k];
  end

  // carry row 0 along for the expansion
  for (genvar j = 0; j < 3; j++) begin : g_row0
    always_ff @(posedge clk) begin
      if (adv) begin
        row0a_r[j] <= m[j];
        row0b_r[j] <= row0a_r[j];
      end
    end
    assign row0[j] = row0b_r[j];
  end

  assign out_valid = vb_r;

endmodule

/* rtl/m3i_det.sv */
// Three-stage determinant unit: split products, recombine, sum along row 0.
module m3i_det (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  m3i_pkg::entry_t                      row0 [3],
  input  logic signed [m3i_pkg::COF_W-1:0]     cof_in [m3i_pkg::NUM_ENTRIES],
  output logic                                 out_valid,
  output logic signed [m3i_pkg::COF_W-1:0]     cof_out [m3i_pkg::NUM_ENTRIES],
  output logic signed [m3i_pkg::DETX_W-1:0]    det
);
  import m3i_pkg::*;

  localparam int PP_W = 2 * DATA_WIDTH + 1;

  logic                     vc_r, vd_r, ve_r;
  logic signed [PP_W-1:0]   lo_r [3];
  logic signed [PP_W-1:0]   hi_r [3];
  logic signed [DETX_W-1:0] term_r [3];
  logic signed [DETX_W-1:0] det_r;
  logic signed [COF_W-1:0]  cofc_r [NUM_ENTRIES];
  logic signed [COF_W-1:0]  cofd_r [NUM_ENTRIES];
  logic signed [COF_W-1:0]  cofe_r [NUM_ENTRIES];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (adv) begin
      vc_r <= in_valid;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  // multiply row 0 by the low and high halves of the first adjugate column
  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk) begin
      if (adv) begin
        lo_r[j]   <= row0[j] * $signed({1'b0, cof_in[3*j][DATA_WIDTH-1:0]});
        hi_r[j]   <= row0[j] * $signed(cof_in[3*j][COF_W-1:DATA_WIDTH]);
        term_r[j] <= (DETX_W'(hi_r[j]) <<< DATA_WIDTH) + DETX_W'(lo_r[j]);
      end
    end
  end

  // sum the three terms
  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  // delay cofactors to line up with the determinant
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cdly
    always_ff @(posedge clk) begin
      if (adv) begin
        cofc_r[k] <= cof_in[k];
        cofd_r[k] <= cofc_r[k];
        cofe_r[k] <= cofd_r[k];
      end
    end
    assign cof_out[k] = cofe_r[k];
  end

  assign out_valid = ve_r;
  assign det       = det_r;

endmodule

/* rtl/m3i_prep.sv */
// Two-stage divide setup: magnitudes, singular test, det output, overflow check.
module m3i_prep #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [m3i_pkg::DETX_W-1:0]     det,
  input  logic signed [m3i_pkg::COF_W-1:0]      cof [m3i_pkg::NUM_ENTRIES],
  input  logic [m3i_pkg::THR_WIDTH-1:0]         thr,
  output logic                                  out_valid,
  output logic                                  out_sing,
  output logic signed [m3i_pkg::DET_WIDTH-1:0]  out_det,
  output logic [m3i_pkg::DETX_W-1:0]            out_den,
  output logic [m3i_pkg::DIV_W-1:0]             out_num [m3i_pkg::NUM_ENTRIES],
  output logic                                  out_neg [m3i_pkg::NUM_ENTRIES],
  output logic                                  out_ovf [m3i_pkg::NUM_ENTRIES]
);
  import m3i_pkg::*;

  localparam logic [DETX_W-1:0] DET_POS_LIM = DETX_W'({(DET_WIDTH-1){1'b1}});
  localparam logic [DETX_W-1:0] DET_NEG_LIM = DET_POS_LIM + 1'b1;

  logic                    vf_r, vg_r;
  logic [DETX_W-1:0]       dmag_r;
  logic                    dneg_r;
  logic [COF_W-1:0]        cmag_r [NUM_ENTRIES];
  logic                    cneg_r [NUM_ENTRIES];

  logic [DETX_W-1:0]       thr_sh, dq, dsat, den_r;
  logic [DIV_W-1:0]        den_sh;
  logic                    sing, sing_r;
  logic signed [DET_WIDTH-1:0] deto, deto_r;
  logic [DIV_W-1:0]        num_r [NUM_ENTRIES];
  logic                    neg_r [NUM_ENTRIES];
  logic                    ovf_r [NUM_ENTRIES];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else if (adv) begin
      vf_r <= in_valid;
      vg_r <= vf_r;
    end
  end

  // take magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      dneg_r <= det[DETX_W-1];
      dmag_r <= det[DETX_W-1] ? DETX_W'(-det) : DETX_W'(det);
    end
  end

  // singular test on the exact value, truncate and clamp the determinant
  always_comb begin
    thr_sh = DETX_W'(thr) << (2 * FRAC_BITS);
    sing   = (dmag_r == '0) || (dmag_r < thr_sh);
    dq     = dmag_r >> (2 * FRAC_BITS);
    if (dneg_r) begin
      dsat = (dq > DET_NEG_LIM) ? DET_NEG_LIM : dq;
      deto = DET_WIDTH'(-dsat);
    end else begin
      dsat = (dq > DET_POS_LIM) ? DET_POS_LIM : dq;
      deto = DET_WIDTH'(dsat);
    end
    den_sh = DIV_W'(dmag_r) << DATA_WIDTH;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= sing;
      deto_r <= deto;
      den_r  <= dmag_r;
    end
  end

  // scale numerators and flag quotients that surely overflow
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_lane
    logic [DIV_W-1:0] num;
    assign num = DIV_W'(cmag_r[k]) << (2 * FRAC_BITS);
    always_ff @(posedge clk) begin
      if (adv) begin
        cneg_r[k] <= cof[k][COF_W-1];
        cmag_r[k] <= cof[k][COF_W-1] ? COF_W'(-cof[k]) : COF_W'(cof[k]);
        num_r[k]  <= num;
        neg_r[k]  <= cneg_r[k] ^ dneg_r;
        ovf_r[k]  <= (num >= den_sh);
      end
    end
    assign out_num[k] = num_r[k];
    assign out_neg[k] = neg_r[k];
    assign out_ovf[k] = ovf_r[k];
  end

  assign out_valid = vg_r;
  assign out_sing  = sing_r;
  assign out_det   = deto_r;
  assign out_den   = den_r;

endmodule

/* rtl/m3i_div.sv */
// Nine-lane restoring divider, one quotient bit per stage, shared divisor line.
module m3i_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic                                  in_sing,
  input  logic signed [m3i_pkg::DET_WIDTH-1:0]  in_det,
  input  logic [m3i_pkg::DETX_W-1:0]            in_den,
  input  logic [m3i_pkg::DIV_W-1:0]             in_num [m3i_pkg::NUM_ENTRIES],
  input  logic                                  in_neg [m3i_pkg::NUM_ENTRIES],
  input  logic                                  in_ovf [m3i_pkg::NUM_ENTRIES],
  output logic                                  out_valid,
  output logic                                  out_sing,
  output logic signed [m3i_pkg::DET_WIDTH-1:0]  out_det,
  output logic [m3i_pkg::DATA_WIDTH-1:0]        out_q [m3i_pkg::NUM_ENTRIES],
  output logic                                  out_neg [m3i_pkg::NUM_ENTRIES],
  output logic                                  out_ovf [m3i_pkg::NUM_ENTRIES]
);
  import m3i_pkg::*;

  localparam int NS = DATA_WIDTH;

  logic                        v_r    [NS];
  logic                        sing_r [NS];
  logic signed [DET_WIDTH-1:0] det_r  [NS];
  logic [DETX_W-1:0]           den_r  [NS];
  logic [DIV_W-1:0]            rem_r  [NS-1][NUM_ENTRIES];
  logic [DATA_WIDTH-1:0]       q_r    [NS][NUM_ENTRIES];
  logic                        neg_r  [NS][NUM_ENTRIES];
  logic                        ovf_r  [NS][NUM_ENTRIES];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic                        v_in, sing_in;
    logic signed [DET_WIDTH-1:0] det_in;
    logic [DETX_W-1:0]           den_in;
    logic [DIV_W-1:0]            trial;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign sing_in = in_sing;
      assign det_in  = in_det;
      assign den_in  = in_den;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign sing_in = sing_r[s-1];
      assign det_in  = det_r[s-1];
      assign den_in  = den_r[s-1];
    end

    assign trial = DIV_W'(den_in) << B;

    // advance valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_in;
      end
    end

    // carry sideband down the line
    always_ff @(posedge clk) begin
      if (adv) begin
        sing_r[s] <= sing_in;
        det_r[s]  <= det_in;
        den_r[s]  <= den_in;
      end
    end

    for (genvar l = 0; l < NUM_ENTRIES; l++) begin : g_lane
      logic [DIV_W-1:0]      rem_in;
      logic [DATA_WIDTH-1:0] q_in;
      logic                  neg_in, ovf_in, ge;

      if (s == 0) begin : g_first
        assign rem_in = in_num[l];
        assign q_in   = '0;
        assign neg_in = in_neg[l];
        assign ovf_in = in_ovf[l];
      end else begin : g_next
        assign rem_in = rem_r[s-1][l];
        assign q_in   = q_r[s-1][l];
        assign neg_in = neg_r[s-1][l];
        assign ovf_in = ovf_r[s-1][l];
      end

      assign ge = (rem_in >= trial);

      // subtract when the shifted divisor fits, set this quotient bit
      always_ff @(posedge clk) begin
        if (adv) begin
          q_r[s][l]   <= q_in | (DATA_WIDTH'(ge) << B);
          neg_r[s][l] <= neg_in;
          ovf_r[s][l] <= ovf_in;
        end
      end

      if (s < NS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            rem_r[s][l] <= ge ? (rem_in - trial) : rem_in;
          end
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_ENTRIES; l++) begin : g_out
    assign out_q[l]   = q_r[NS-1][l];
    assign out_neg[l] = neg_r[NS-1][l];
    assign out_ovf[l] = ovf_r[NS-1][l];
  end

  assign out_valid = v_r[NS-1];
  assign out_sing  = sing_r[NS-1];
  assign out_det   = det_r[NS-1];

endmodule

/* rtl/matrix3x3_inverse.sv */
// Top level of the 3x3 matrix inverse: pipeline stages, threshold register, output register.
//
// Takes one 3x3 Q16.16 matrix per transaction and returns its determinant (Q32.16,
// truncated toward zero, saturated), a singular flag and the inverse (adjugate over
// determinant, truncated toward zero, saturated; all zero when singular). A new
// transaction is accepted every cycle unless the pipeline holds; it passes through the
// cofactor stages, determinant stages, divide setup, the bit-per-stage divider lanes
// (one stage per quotient bit of DATA_WIDTH) and the output register. The whole pipeline
// holds while a result waits at the output, so in_ready drops only when out_ready is low.
// cfg_wr_data sets the singular threshold (unsigned Q31.16, reset 1 LSB); write it only when idle.
`include "assert_macros.svh"

module matrix3x3_inverse #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  m3i_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output m3i_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [m3i_pkg::THR_WIDTH-1:0]  cfg_wr_data
);
  import m3i_pkg::*;

  localparam logic [DATA_WIDTH-1:0] Q_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] Q_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                 adv;
  logic [THR_WIDTH-1:0] thr_r;
  entry_t               m [NUM_ENTRIES];

  logic                    cof_valid;
  entry_t                  row0 [3];
  logic signed [COF_W-1:0] cof [NUM_ENTRIES];

  logic                     det_valid;
  logic signed [COF_W-1:0]  cof_d [NUM_ENTRIES];
  logic signed [DETX_W-1:0] det;

  logic                        prep_valid, prep_sing;
  logic signed [DET_WIDTH-1:0] prep_det;
  logic [DETX_W-1:0]           prep_den;
  logic [DIV_W-1:0]            prep_num [NUM_ENTRIES];
  logic                        prep_neg [NUM_ENTRIES];
  logic                        prep_ovf [NUM_ENTRIES];

  logic                        div_valid, div_sing;
  logic signed [DET_WIDTH-1:0] div_det;
  logic [DATA_WIDTH-1:0]       div_q [NUM_ENTRIES];
  logic                        div_neg [NUM_ENTRIES];
  logic                        div_ovf [NUM_ENTRIES];

  entry_t    inv [NUM_ENTRIES];
  out_item_t out_nxt, out_data_r;
  logic      out_valid_r, out_valid_nxt;

  // hold everything while a result waits
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  assign m[0] = in_data.entry_r0c0;
  assign m[1] = in_data.entry_r0c1;
  assign m[2] = in_data.entry_r0c2;
  assign m[3] = in_data.entry_r1c0;
  assign m[4] = in_data.entry_r1c1;
  assign m[5] = in_data.entry_r1c2;
  assign m[6] = in_data.entry_r2c0;
  assign m[7] = in_data.entry_r2c1;
  assign m[8] = in_data.entry_r2c2;

  m3i_cof u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .m         (m),
    .out_valid (cof_valid),
    .row0      (row0),
    .cof       (cof)
  );

  m3i_det u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cof_valid),
    .row0      (row0),
    .cof_in    (cof),
    .out_valid (det_valid),
    .cof_out   (cof_d),
    .det       (det)
  );

  m3i_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (det_valid),
    .det       (det),
    .cof       (cof_d),
    .thr       (thr_r),
    .out_valid (prep_valid),
    .out_sing  (prep_sing),
    .out_det   (prep_det),
    .out_den   (prep_den),
    .out_num   (prep_num),
    .out_neg   (prep_neg),
    .out_ovf   (prep_ovf)
  );

  m3i_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (prep_valid),
    .in_sing   (prep_sing),
    .in_det    (prep_det),
    .in_den    (prep_den),
    .in_num    (prep_num),
    .in_neg    (prep_neg),
    .in_ovf    (prep_ovf),
    .out_valid (div_valid),
    .out_sing  (div_sing),
    .out_det   (div_det),
    .out_q     (div_q),
    .out_neg   (div_neg),
    .out_ovf   (div_ovf)
  );

  // saturate, apply sign, drop to zero when singular
  for (genvar l = 0; l < NUM_ENTRIES; l++) begin : g_sat
    always_comb begin
      if (div_sing) begin
        inv[l] = '0;
      end else if (div_neg[l]) begin
        inv[l] = (div_ovf[l] || div_q[l] > Q_NEG) ? entry_t'(Q_NEG) : entry_t'(-div_q[l]);
      end else begin
        inv[l] = (div_ovf[l] || div_q[l] > Q_POS) ? entry_t'(Q_POS) : entry_t'(div_q[l]);
      end
    end
  end

  always_comb begin
    out_nxt           = out_data_r;
    out_valid_nxt     = out_valid_r;
    if (adv) begin
      out_valid_nxt     = div_valid;
      out_nxt.det_value = div_det;
      out_nxt.singular  = div_sing;
      out_nxt.inv_r0c0  = inv[0];
      out_nxt.inv_r0c1  = inv[1];
      out_nxt.inv_r0c2  = inv[2];
      out_nxt.inv_r1c0  = inv[3];
      out_nxt.inv_r1c1  = inv[4];
      out_nxt.inv_r1c2  = inv[5];
      out_nxt.inv_r2c0  = inv[6];
      out_nxt.inv_r2c1  = inv[7];
      out_nxt.inv_r2c2  = inv[8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a singular result carries an all-zero inverse
  `M3I_ASSERT_IMP(a_sing_zero_inv, clk, rst_n, out_valid_r && out_data_r.singular, out_data_r.inv_r0c0 == '0 && out_data_r.inv_r0c1 == '0 && out_data_r.inv_r0c2 == '0 && out_data_r.inv_r1c0 == '0 && out_data_r.inv_r1c1 == '0 && out_data_r.inv_r1c2 == '0 && out_data_r.inv_r2c0 == '0 && out_data_r.inv_r2c1 == '0 && out_data_r.inv_r2c2 == '0)
  // a stall never drops the waiting result
  `M3I_ASSERT_NXT(a_stall_keeps_out, clk, rst_n, !in_ready, out_valid_r)

endmodule

/* sim/tb_matrix3x3_inverse.sv */
// Testbench for matrix3x3_inverse: directed and random matrices checked against a predictor.
module tb_matrix3x3_inverse;
  import m3i_pkg::*;

  localparam int LATENCY    = 40;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1440;
  localparam logic [THR_WIDTH-1:0] THR_MAX = {THR_WIDTH{1'b1}};
  localparam logic [DATA_WIDTH-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [DATA_WIDTH-1:0] TWO_Q   = 32'h0002_0000;
  localparam logic [DATA_WIDTH-1:0] MAX_Q   = 32'h7fff_ffff;
  localparam logic [DATA_WIDTH-1:0] MIN_Q   = 32'h8000_0000;

  // cofactor index table: adj[k] = m[p]*m[q] - m[s]*m[t], negated where flagged
  localparam int COF_P [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int COF_Q [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int COF_S [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int COF_T [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam bit COF_N [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [THR_WIDTH-1:0] cfg_wr_data;

  logic [THR_WIDTH-1:0] threshold_q;
  out_item_t            pending_results[$];
  int                   fail_count = 0;
  int                   idle_cycles = 0;
  bit                   fast_mode = 0;
  bit                   hold_long = 0;

  matrix3x3_inverse i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Clamp a sign and magnitude to a signed field of width w
  function automatic logic [63:0] clamp_field(bit neg, logic [191:0] mag, int w);
    logic [191:0] limit;
    logic [191:0] m;
    logic [63:0]  mask;
    limit = 192'(1) << (w - 1);
    mask  = (64'(1) << w) - 64'(1);
    if (!neg) begin
      m = (mag > limit - 192'(1)) ? limit - 192'(1) : mag;
      return m[63:0] & mask;
    end
    m = (mag > limit) ? limit : mag;
    m = -m;
    return m[63:0] & mask;
  endfunction

  // Determinant, singular flag and inverse of one matrix
  function automatic out_item_t invert_matrix(in_item_t mi, logic [THR_WIDTH-1:0] thr);
    logic signed [127:0] m[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    logic [191:0]        det_mag;
    logic [191:0]        adj_mag;
    logic [191:0]        quo;
    logic [63:0]         det_out;
    logic [31:0]         inv[9];
    bit                  sing;
    for (int k = 0; k < 9; k++) m[k] = $signed(mi[(8-k)*32 +: 32]);
    for (int k = 0; k < 9; k++) begin
      adj[k] = m[COF_P[k]] * m[COF_Q[k]] - m[COF_S[k]] * m[COF_T[k]];
      if (COF_N[k]) adj[k] = -adj[k];
    end
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    det_mag = (det < 0) ? -det : det;
    sing = (det == 0) || (det_mag < (192'(thr) << 32));
    det_out = clamp_field(det < 0, det_mag >> 32, DET_WIDTH);
    for (int k = 0; k < 9; k++) begin
      inv[k] = '0;
      if (!sing) begin
        adj_mag = (adj[k] < 0) ? -adj[k] : adj[k];
        quo = (adj_mag << 32) / det_mag;
        inv[k] = DATA_WIDTH'(clamp_field((adj[k] < 0) != (det < 0), quo, DATA_WIDTH));
      end
    end
    return out_item_t'({det_out[DET_WIDTH-1:0], sing, inv[0], inv[1], inv[2], inv[3],
                        inv[4], inv[5], inv[6], inv[7], inv[8]});
  endfunction

  function automatic in_item_t pack_matrix(logic [31:0] e[9]);
    return in_item_t'({e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]});
  endfunction

  function automatic in_item_t diag_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] e[9];
    foreach (e[k]) e[k] = '0;
    e[0] = a; e[4] = b; e[8] = c;
    return pack_matrix(e);
  endfunction

  function automatic in_item_t fill_matrix(logic [31:0] v);
    logic [31:0] e[9];
    foreach (e[k]) e[k] = v;
    return pack_matrix(e);
  endfunction

  // Result with a diagonal inverse, for rows whose answer is known by hand
  function automatic out_item_t diag_result(logic [47:0] det, bit sing, logic [31:0] d);
    return out_item_t'({det, sing, d, 32'd0, 32'd0, 32'd0, d, 32'd0, 32'd0, 32'd0, d});
  endfunction

  // Random matrix drawn from a mix of shapes
  function automatic in_item_t random_matrix();
    logic [31:0] e[9];
    int          kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind) inside
        [0:2]: e[k] = $urandom;
        [3:7]: e[k] = 32'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
        8: e[k] = 32'($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000;
        default: e[k] = 32'($urandom_range(0, 32)) - 32'd16;
      endcase
    end
    // make row 2 a near copy of row 0 plus row 1
    if (kind == 6) begin
      for (int c = 0; c < 3; c++) e[6+c] = e[c] + e[3+c] + 32'($urandom_range(0, 3));
    end
    // keep only the diagonal with small off-diagonal noise
    if (kind == 7) begin
      for (int k = 0; k < 9; k++) begin
        if (k % 4 != 0) e[k] = 32'($urandom_range(0, 7));
      end
    end
    return pack_matrix(e);
  endfunction

  // Offer one matrix, hold until accepted, then queue its expected result
  task automatic send_matrix(in_item_t mi, bit typed, out_item_t typed_res);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= mi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(typed ? typed_res : invert_matrix(mi, threshold_q));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_WIDTH-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    threshold_q = v;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no matrix outstanding");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("det_value", 64'(e.det_value), 64'(out_data.det_value));
        check_field("singular", 64'(e.singular), 64'(out_data.singular));
        check_field("inv_r0c0", 64'(e.inv_r0c0), 64'(out_data.inv_r0c0));
        check_field("inv_r0c1", 64'(e.inv_r0c1), 64'(out_data.inv_r0c1));
        check_field("inv_r0c2", 64'(e.inv_r0c2), 64'(out_data.inv_r0c2));
        check_field("inv_r1c0", 64'(e.inv_r1c0), 64'(out_data.inv_r1c0));
        check_field("inv_r1c1", 64'(e.inv_r1c1), 64'(out_data.inv_r1c1));
        check_field("inv_r1c2", 64'(e.inv_r1c2), 64'(out_data.inv_r1c2));
        check_field("inv_r2c0", 64'(e.inv_r2c0), 64'(out_data.inv_r2c0));
        check_field("inv_r2c1", 64'(e.inv_r2c1), 64'(out_data.inv_r2c1));
        check_field("inv_r2c2", 64'(e.inv_r2c2), 64'(out_data.inv_r2c2));
      end
    end
  end

  // Drop out_ready for random stretches, with one long hold on request
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = fast_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_item_t             dir_mat[$];
    bit                   dir_typed[$];
    out_item_t            dir_res[$];
    logic [THR_WIDTH-1:0] thr_phase[5];
    logic [31:0]          e[9];
    int                   per_phase;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    threshold_q = THR_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset threshold
    dir_mat.push_back(fill_matrix('0));
    dir_typed.push_back(1); dir_res.push_back(diag_result('0, 1, '0));
    dir_mat.push_back(diag_matrix(ONE_Q, ONE_Q, ONE_Q));
    dir_typed.push_back(1); dir_res.push_back(diag_result(48'h1_0000, 0, ONE_Q));
    dir_mat.push_back(diag_matrix(TWO_Q, TWO_Q, TWO_Q));
    dir_typed.push_back(1); dir_res.push_back(diag_result(48'h8_0000, 0, 32'h8000));
    dir_mat.push_back(fill_matrix(MAX_Q));
    dir_typed.push_back(1); dir_res.push_back(diag_result('0, 1, '0));
    dir_mat.push_back(fill_matrix(MIN_Q));
    dir_typed.push_back(1); dir_res.push_back(diag_result('0, 1, '0));
    dir_mat.push_back(diag_matrix(MAX_Q, MAX_Q, MAX_Q));
    dir_mat.push_back(diag_matrix(MIN_Q, MIN_Q, MIN_Q));
    dir_mat.push_back(diag_matrix(MIN_Q, MAX_Q, MIN_Q));
    dir_mat.push_back(diag_matrix(32'd1, 32'd1, 32'd1));
    dir_mat.push_back(diag_matrix(32'hffff_ffff, ONE_Q, ONE_Q));
    dir_mat.push_back(diag_matrix(32'd256, 32'd256, 32'd256));
    dir_mat.push_back(diag_matrix(32'h0100_0000, 32'h0100_0000, 32'd1));
    // row swap gives a negative determinant
    foreach (e[k]) e[k] = '0;
    e[1] = ONE_Q; e[3] = ONE_Q; e[8] = 32'h0003_8000;
    dir_mat.push_back(pack_matrix(e));
    foreach (e[k]) e[k] = 32'(k + 1) << 16;
    dir_mat.push_back(pack_matrix(e));
    e[8] = 32'h000a_0000;
    dir_mat.push_back(pack_matrix(e));
    for (int k = 0; k < 6; k++) dir_mat.push_back(random_matrix());
    while (dir_typed.size() < dir_mat.size()) begin
      dir_typed.push_back(0);
      dir_res.push_back('0);
    end
    foreach (dir_mat[i]) send_matrix(dir_mat[i], dir_typed[i], dir_res[i]);
    drain_results();

    // random phases, each under its own threshold
    thr_phase[0] = '0;
    thr_phase[1] = THR_MAX;
    thr_phase[2] = THR_WIDTH'($urandom_range(1, 32'h0010_0000));
    thr_phase[3] = THR_WIDTH'({$urandom, $urandom});
    thr_phase[4] = THR_RESET;
    per_phase = RAND_ITEMS / 5;
    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_phase[p]);
      send_matrix(fill_matrix('0), 0, '0);
      send_matrix(diag_matrix(32'd1, 32'd1, 32'd1), 0, '0);
      for (int i = 0; i < per_phase; i++) begin
        if (i % 50 == 0) fast_mode = ($urandom_range(0, 3) == 0);
        // fill the pipeline behind a stalled receiver
        if (p == 2 && i == 100) begin
          fast_mode = 1;
          hold_long = 1;
          for (int j = 0; j < 80; j++) send_matrix(random_matrix(), 0, '0);
          fast_mode = 0;
        end
        // pause until every result is back
        if (p == 3 && i == 150) drain_results();
        send_matrix(random_matrix(), 0, '0);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
